/* hdl/smx_pkg.sv */
// Shared types and constants for the softmax normalizer.
// Depends on nothing; used by every module under hdl.
package smx_pkg;

    localparam int LOGIT_W = 16;
    localparam int PROB_W  = 16;
    localparam int SUM_W   = 23;

    // Item passed from the front end to the back end
    typedef struct packed {
        logic [LOGIT_W-1:0] logit;
        logic               last;
    } smx_item_t;

    // exp(-k) for integer k, Q1.16
    function automatic logic [16:0] exp_int(input logic [4:0] k);
        logic [16:0] r;
        begin
            unique case (k)
                5'd0:  r = 17'd65536;
                5'd1:  r = 17'd24109;
                5'd2:  r = 17'd8869;
                5'd3:  r = 17'd3263;
                5'd4:  r = 17'd1200;
                5'd5:  r = 17'd442;
                5'd6:  r = 17'd162;
                5'd7:  r = 17'd60;
                5'd8:  r = 17'd22;
                5'd9:  r = 17'd8;
                5'd10: r = 17'd3;
                5'd11: r = 17'd1;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

    // exp(-h/16), Q1.16
    function automatic logic [16:0] exp_sixteenth(input logic [3:0] h);
        logic [16:0] r;
        begin
            unique case (h)
                4'd0:  r = 17'd65536;
                4'd1:  r = 17'd61565;
                4'd2:  r = 17'd57835;
                4'd3:  r = 17'd54331;
                4'd4:  r = 17'd51039;
                4'd5:  r = 17'd47947;
                4'd6:  r = 17'd45042;
                4'd7:  r = 17'd42314;
                4'd8:  r = 17'd39750;
                4'd9:  r = 17'd37341;
                4'd10: r = 17'd35079;
                4'd11: r = 17'd32954;
                4'd12: r = 17'd30957;
                4'd13: r = 17'd29081;
                4'd14: r = 17'd27319;
                default: r = 17'd25664;
            endcase
            return r;
        end
    endfunction

    // exp(-l/256), Q1.16
    function automatic logic [16:0] exp_fine(input logic [3:0] l);
        logic [16:0] r;
        begin
            unique case (l)
                4'd0:  r = 17'd65536;
                4'd1:  r = 17'd65280;
                4'd2:  r = 17'd65026;
                4'd3:  r = 17'd64772;
                4'd4:  r = 17'd64520;
                4'd5:  r = 17'd64268;
                4'd6:  r = 17'd64018;
                4'd7:  r = 17'd63768;
                4'd8:  r = 17'd63520;
                4'd9:  r = 17'd63272;
                4'd10: r = 17'd63025;
                4'd11: r = 17'd62781;
                4'd12: r = 17'd62535;
                4'd13: r = 17'd62291;
                4'd14: r = 17'd62048;
                default: r = 17'd61806;
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/smx_front.sv */
// Front end: takes input items into a two-entry queue for the back end.
// Depends on smx_pkg.
module smx_front
    import smx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  smx_item_t in_item,
    output logic      q_valid,
    input  logic      q_pop,
    output smx_item_t q_item
);

    smx_item_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !q_pop) |=> in_stall) else $error("full queue not stalled");
`endif

endmodule

/* hdl/smx_divider.sv */
// Restoring divider: 40-bit dividend over 23-bit divisor, one quotient bit per cycle.
// Depends on smx_pkg.
module smx_divider
    import smx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [39:0]      dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic             done,
    output logic [39:0]      quotient
);

    logic [39:0]      q_reg;
    logic [SUM_W:0]   rem_reg;
    logic [SUM_W-1:0] den_reg;
    logic [5:0]       step_reg;
    logic             busy_reg;
    logic [SUM_W+1:0] trial;
    logic [SUM_W+1:0] shifted;

    assign shifted  = {rem_reg, q_reg[39]};
    assign trial    = shifted - {2'b00, den_reg};
    assign done     = busy_reg && (step_reg == 6'd0);
    assign quotient = q_reg;

    // Shift in one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 6'd0;
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 6'd40;
            q_reg    <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (step_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 6'd1;
                if (!trial[SUM_W+1])
                begin
                    rem_reg <= trial[SUM_W:0];
                    q_reg   <= {q_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[SUM_W:0];
                    q_reg   <= {q_reg[38:0], 1'b0};
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 6'd0) |-> busy_reg) else $error("divider step without busy");
    a_done_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start) |=> !busy_reg) else $error("divider stayed busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && step_reg == 6'd40)) else $error("divider did not start");
`endif

endmodule

/* hdl/smx_back.sv */
// Back end: buffers the vector, exponentiates, sums and normalizes.
// Depends on smx_pkg and smx_divider.
module smx_back
    import smx_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  smx_item_t         q_item,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PROB_W-1:0] probability,
    output logic              status,
    output logic              end_of_run
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        ST_LOAD  = 8'b00000001,
        ST_ERD   = 8'b00000010,
        ST_EMUL1 = 8'b00000100,
        ST_EMUL2 = 8'b00001000,
        ST_EWR   = 8'b00010000,
        ST_DRD   = 8'b00100000,
        ST_DDIV  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t                state_reg, state_next;
    logic [LOGIT_W-1:0]    store [DEPTH];
    logic [LOGIT_W-1:0]    rd_data_reg;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [LOGIT_W-1:0]    wr_data;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         idx_reg;
    logic signed [LOGIT_W-1:0] max_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  ovf_reg;
    logic [12:0]           diff_reg;
    logic                  zero_reg;
    logic [16:0]           v_reg;
    logic [33:0]           prod;
    logic [16:0]           rounded;
    logic [16:0]           mul_b;
    logic [16:0]           e_val;
    logic [PROB_W-1:0]     prob_reg;
    logic                  status_reg, eor_reg;
    logic                  div_go_reg;
    logic                  div_start, div_done;
    logic [39:0]           div_q;
    logic [16:0]           full_diff;
    logic                  is_last_idx;

    assign q_pop = (state_reg == ST_LOAD) && q_valid;
    assign out_valid   = (state_reg == ST_OUT);
    assign probability = prob_reg;
    assign status      = status_reg;
    assign end_of_run  = eor_reg;
    assign is_last_idx = (idx_reg + CW'(1) == count_reg);

    // Buffer write during load and write-back of exponentials
    assign wr_en   = (q_pop && count_reg != CW'(DEPTH)) || (state_reg == ST_EWR);
    assign wr_addr = (state_reg == ST_LOAD) ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data = (state_reg == ST_LOAD) ? q_item.logit : e_val[15:0];
    assign rd_addr = idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
        rd_data_reg <= store[rd_addr];
    end

    // Exponential: one table multiply per cycle, sixteenth step then fine step
    assign full_diff = {max_reg[LOGIT_W-1], max_reg} - {rd_data_reg[LOGIT_W-1], rd_data_reg};
    assign mul_b   = (state_reg == ST_EMUL2) ? exp_sixteenth(diff_reg[7:4])
                                             : exp_fine(diff_reg[3:0]);
    assign prod    = v_reg * mul_b;
    assign rounded = 17'((prod + 34'd32768) >> 16);
    assign e_val   = zero_reg ? 17'd0 : ((rounded > 17'd65535) ? 17'd65535 : rounded);

    // Start the divide in the cycle after the read, once the buffer data is registered
    assign div_start = div_go_reg;

    smx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({8'd0, rd_data_reg, 16'd0} + {17'd0, sum_reg >> 1}),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequence the passes
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (q_pop && q_item.last)
                begin
                    if (ovf_reg || count_reg == CW'(DEPTH))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_ERD;
                    end
                end
            end
            ST_ERD:   state_next = ST_EMUL1;
            ST_EMUL1: state_next = ST_EMUL2;
            ST_EMUL2: state_next = ST_EWR;
            ST_EWR:   state_next = is_last_idx ? ST_DRD : ST_ERD;
            ST_DRD:   state_next = ST_DDIV;
            ST_DDIV:  state_next = div_done ? ST_OUT : ST_DDIV;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = (status_reg || eor_reg) ? ST_LOAD : ST_DRD;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            idx_reg    <= '0;
            max_reg    <= {1'b1, {(LOGIT_W-1){1'b0}}};
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
            status_reg <= 1'b0;
            eor_reg    <= 1'b0;
            prob_reg   <= '0;
            diff_reg   <= '0;
            zero_reg   <= 1'b0;
            v_reg      <= '0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == ST_DRD);
            unique case (state_reg)
                ST_LOAD:
                begin
                    idx_reg <= '0;
                    sum_reg <= '0;
                    if (q_pop)
                    begin
                        if (count_reg != CW'(DEPTH))
                        begin
                            count_reg <= count_reg + CW'(1);
                            if ($signed(q_item.logit) > max_reg)
                            begin
                                max_reg <= $signed(q_item.logit);
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (q_item.last && (ovf_reg || count_reg == CW'(DEPTH)))
                        begin
                            prob_reg   <= '0;
                            status_reg <= 1'b1;
                            eor_reg    <= 1'b1;
                        end
                    end
                end
                ST_ERD:
                begin
                end
                ST_EMUL1:
                begin
                    diff_reg <= full_diff[12:0];
                    zero_reg <= (full_diff > 17'd4096);
                    v_reg    <= exp_int({1'b0, full_diff[11:8]} | {full_diff[12], 4'd0});
                end
                ST_EMUL2:
                begin
                    v_reg <= rounded;
                end
                ST_EWR:
                begin
                    sum_reg <= sum_reg + SUM_W'(e_val);
                    idx_reg <= is_last_idx ? '0 : idx_reg + CW'(1);
                end
                ST_DRD:
                begin
                end
                ST_DDIV:
                begin
                    if (div_done)
                    begin
                        prob_reg   <= (div_q > 40'd65535) ? 16'hFFFF : div_q[15:0];
                        status_reg <= 1'b0;
                        eor_reg    <= is_last_idx;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (status_reg || eor_reg)
                        begin
                            count_reg  <= '0;
                            idx_reg    <= '0;
                            max_reg    <= {1'b1, {(LOGIT_W-1){1'b0}}};
                            sum_reg    <= '0;
                            ovf_reg    <= 1'b0;
                            status_reg <= 1'b0;
                            eor_reg    <= 1'b0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            // Hold the sixteenth-step product for the fine multiply in ST_EWR
            if (state_reg == ST_EMUL2)
            begin
                v_reg <= rounded;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("count past depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(prob_reg)))
        else $error("result changed under stall");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg) |-> (prob_reg == '0 && eor_reg))
        else $error("bad error result");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !q_pop) else $error("pop while busy");
`endif

endmodule

/* hdl/softmax_normalizer.sv */
// Top level of the softmax normalizer: front-end queue and back-end engine.
// Depends on smx_pkg, smx_front and smx_back.
//
// Logits stream in, one Q8.8 item per cycle while loading unless in_stall is
// raised, into a DEPTH-entry buffer; the item with last closes the vector. The
// engine then computes exp(x - max) for each element (buffer read, integer table
// lookup, two table multiplies, write-back), then a normalizing divide per element,
// which is a restoring divider producing one quotient bit per cycle. An
// overlong vector yields a single result with status set. Input items keep
// landing in a two-entry queue while the engine works, until it is full.
module softmax_normalizer
    import smx_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [LOGIT_W-1:0] logit,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PROB_W-1:0] probability,
    output logic              status,
    output logic              end_of_run
);

    smx_item_t in_item;
    smx_item_t q_item;
    logic      q_valid;
    logic      q_pop;

    assign in_item.logit = logit;
    assign in_item.last  = last;

    smx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    smx_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .probability (probability),
        .status      (status),
        .end_of_run  (end_of_run)
    );

endmodule

/* bench/softmax_normalizer_tb.sv */
`timescale 1ns / 100ps
// Testbench for softmax_normalizer: drives logit vectors, predicts each probability.
// Depends on smx_pkg and the softmax_normalizer RTL.
module softmax_normalizer_tb;
    import smx_pkg::*;

    localparam int DEPTH     = 64;
    localparam int MAX_CYC   = 1500000;
    localparam bit ST_OK     = 1'b0;
    localparam bit ST_OVER   = 1'b1;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              status;
        logic              end_of_run;
    } prob_t;

    // one directed row: item plus optional typed-in result for the last output
    typedef struct {
        logic [15:0] logit;
        logic        last;
        bit          typed;
        prob_t       want;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [LOGIT_W-1:0] logit = '0;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PROB_W-1:0] probability;
    logic              status;
    logic              end_of_run;

    // predictor state
    logic [15:0] vec_buf [DEPTH];
    int          vec_len;
    int          vec_max;
    bit          vec_over;

    prob_t expected_probs [$];
    int    errors = 0;
    int    cycles = 0;
    int    results_seen = 0;
    int    vectors_sent = 0;
    int    overflow_vectors = 0;

    softmax_normalizer #(.DEPTH(DEPTH)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fixed-point exp(-a/256), 0 below -16
    function automatic int unsigned exp_neg(input int unsigned a);
        longint unsigned v;
        int unsigned ktab [17] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
                                   8, 3, 1, 0, 0, 0, 0, 0};
        int unsigned htab [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42314,
                                   39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
        int unsigned ltab [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                                   63520, 63272, 63025, 62781, 62535, 62291, 62048, 61806};
        if (a > 4096)
            return 0;
        v = ktab[a >> 8];
        v = (v * htab[(a >> 4) & 15] + 32768) >> 16;
        v = (v * ltab[a & 15] + 32768) >> 16;
        return (v > 65535) ? 65535 : int'(v);
    endfunction

    // absorb one item; on last, queue the normalized probabilities, or one overflow result
    task automatic predict_softmax(input logic [15:0] x, input logic is_last);
        int unsigned e [DEPTH];
        int unsigned sum;
        longint unsigned p;
        prob_t r;
        if (vec_len < DEPTH)
        begin
            vec_buf[vec_len] = x;
            vec_len++;
            if ($signed(x) > vec_max)
                vec_max = $signed(x);
        end
        else
            vec_over = 1'b1;
        if (!is_last)
            return;
        vectors_sent++;
        if (vec_over)
        begin
            overflow_vectors++;
            r.probability = '0;
            r.status = ST_OVER;
            r.end_of_run = 1'b1;
            expected_probs.push_back(r);
        end
        else
        begin
            sum = 0;
            for (int i = 0; i < vec_len; i++)
            begin
                e[i] = exp_neg(vec_max - int'($signed(vec_buf[i])));
                sum = (sum + e[i]) & 32'h7FFFFF;
            end
            for (int i = 0; i < vec_len; i++)
            begin
                p = (sum == 0) ? 0 : ((longint'(e[i]) << 16) + (sum >> 1)) / sum;
                r.probability = (p > 65535) ? 16'hFFFF : p[15:0];
                r.status = ST_OK;
                r.end_of_run = (i == vec_len - 1);
                expected_probs.push_back(r);
            end
        end
        vec_len = 0;
        vec_max = -32768;
        vec_over = 1'b0;
    endtask

    // mostly short gaps, a few long
    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 45)
            return 0;
        if (g < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // hand one item over and wait for its acceptance
    task automatic send_item(input logic [15:0] x, input logic is_last);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        logit <= x;
        last <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_softmax(x, is_last);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        prob_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_probs.size() == 0)
            begin
                $error("unexpected result probability=%0d", probability);
                errors++;
            end
            else
            begin
                want = expected_probs.pop_front();
                if (probability !== want.probability)
                begin
                    $error("probability: expected %0d, got %0d", want.probability, probability);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (end_of_run !== want.end_of_run)
                begin
                    $error("end_of_run: expected %0d, got %0d", want.end_of_run, end_of_run);
                    errors++;
                end
            end
        end
    end

    // random receiver stalls
    always @(posedge clk)
    begin
        int s;
        s = $urandom_range(0, 99);
        if (s < 60)
            out_stall <= 1'b0;
        else if (s < 97)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // check the typed-in value of a directed row against the predictor
    task automatic check_row(input row_t r);
        if (r.typed && expected_probs.size() > 0)
        begin
            if (expected_probs[expected_probs.size() - 1] != r.want)
            begin
                $error("directed row: predictor disagrees with typed result");
                errors++;
            end
        end
    endtask

    initial
    begin
        row_t dir [$];
        row_t r;
        int n;
        int kind;
        int items;
        logic [15:0] base;

        vec_len = 0;
        vec_max = -32768;
        vec_over = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: single elements at the extremes, ties, far spreads
        r.typed = 1'b1;
        r.want = '{16'hFFFF, ST_OK, 1'b1};
        r.logit = 16'h8000; r.last = 1'b1; dir.push_back(r);
        r.logit = 16'h7FFF; dir.push_back(r);
        r.logit = 16'h0000; dir.push_back(r);
        r.logit = 16'hFFFF; dir.push_back(r);
        r.typed = 1'b0;
        // two equal logits: half each
        r.logit = 16'h0100; r.last = 1'b0; dir.push_back(r);
        r.typed = 1'b1; r.want = '{16'd32768, ST_OK, 1'b1};
        r.last = 1'b1; dir.push_back(r);
        r.typed = 1'b0;
        // difference exactly -16 and just below
        r.logit = 16'h1000; r.last = 1'b0; dir.push_back(r);
        r.logit = 16'h0000; dir.push_back(r);
        r.logit = 16'hFFFF; r.last = 1'b1; dir.push_back(r);
        // full range spread
        r.logit = 16'h7FFF; r.last = 1'b0; dir.push_back(r);
        r.logit = 16'h8000; dir.push_back(r);
        r.logit = 16'h7F00; dir.push_back(r);
        r.logit = 16'h7FF0; r.last = 1'b1; dir.push_back(r);
        // fine steps
        r.logit = 16'h0001; r.last = 1'b0; dir.push_back(r);
        r.logit = 16'h0010; dir.push_back(r);
        r.logit = 16'h00FF; dir.push_back(r);
        r.logit = 16'h5555; dir.push_back(r);
        r.logit = 16'hAAAA; r.last = 1'b1; dir.push_back(r);
        foreach (dir[i])
        begin
            send_item(dir[i].logit, dir[i].last);
            check_row(dir[i]);
        end

        // exactly DEPTH elements, then an overlong vector
        for (int i = 0; i < DEPTH; i++)
            send_item(16'(i * 37), i == DEPTH - 1);
        for (int i = 0; i <= DEPTH; i++)
            send_item(16'($urandom), i == DEPTH);
        r.typed = 1'b1; r.want = '{16'd0, ST_OVER, 1'b1};
        check_row(r);

        // hold off until every result is out
        drop_valid();
        while (expected_probs.size() != 0)
            @(posedge clk);

        // random vectors, mostly short with close logits; count the directed items too
        items = dir.size() + 2 * DEPTH + 1;
        while (items < 180)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                n = $urandom_range(DEPTH - 2, DEPTH + 3);
            else
                n = $urandom_range(1, 8);
            base = 16'($urandom);
            for (int i = 0; i < n; i++)
            begin
                if (kind < 12)
                    send_item(base + 16'($urandom_range(0, 16'h1200)) - 16'h0900, i == n - 1);
                else
                    send_item(16'($urandom), i == n - 1);
            end
            items += n;
            if (kind == 5)
            begin
                drop_valid();
                while (expected_probs.size() != 0)
                    @(posedge clk);
            end
        end
        drop_valid();

        while (expected_probs.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d vectors (%0d overlong), %0d results checked",
                 vectors_sent, overflow_vectors, results_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* softmax_normalizer.f */
hdl/smx_pkg.sv
hdl/smx_front.sv
hdl/smx_divider.sv
hdl/smx_back.sv
hdl/softmax_normalizer.sv
bench/softmax_normalizer_tb.sv
